@@ rtl/ltssa_pkg.sv @@
package ltssa_pkg;

   localparam int LOAD_FRACTION_BITS = 8;

   localparam int LOAD_W  = 16;
   localparam int TIME_W  = 64;
   localparam int IVL_W   = 52;
   localparam int COUNT_W = 9;
   localparam int CSR_INDEX_W = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // smallest interval whose whole seconds exceed one month (2592000 s)
   localparam logic [IVL_W-1:0] IVL_LIMIT = IVL_W'(64'd2592001000000000);

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_START_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_THRESHOLD  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_HOLDOFF   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_HOLDOFF    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUIET_OVER_START = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUIET_OVER_STOP  = 3'd5;

   typedef enum logic [1:0] {
      KIND_POLL  = 2'd0,
      KIND_START = 2'd1,
      KIND_STOP  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_LOAD_FAIL  = 2'd1,
      ST_CLOCK_FAIL = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [TIME_W-1:0] time_now;
      logic [LOAD_W-1:0] load_sample;
      logic              load_ok;
      logic              clock_ok;
   } item_type;

   typedef struct packed {
      logic [LOAD_W-1:0] start_threshold;
      logic [LOAD_W-1:0] stop_threshold;
      logic [IVL_W-1:0]  start_holdoff_ns;
      logic [IVL_W-1:0]  stop_holdoff_ns;
      logic [IVL_W-1:0]  quiet_after_over_start_ns;
      logic [IVL_W-1:0]  quiet_after_over_stop_ns;
   } cfg_type;

   typedef struct packed {
      status_type         status;
      logic [COUNT_W-1:0] start_jobs;
      logic [COUNT_W-1:0] stop_jobs;
   } result_type;

   // floor(excess) + 1 in whole load units, saturated to the count width
   function automatic logic [COUNT_W-1:0] advise_count(input logic [LOAD_W-1:0] excess);
      logic [LOAD_W:0] c;
      c = (LOAD_W+1)'(excess >> LOAD_FRACTION_BITS) + (LOAD_W+1)'(1);
      return (c > (LOAD_W+1)'(COUNT_MAX)) ? COUNT_MAX : c[COUNT_W-1:0];
   endfunction

   // strict test limit < elapsed, elapsed taken as zero when time ran backward
   function automatic logic elapsed_over(input logic [TIME_W-1:0] now,
                                         input logic [TIME_W-1:0] then,
                                         input logic [IVL_W-1:0]  limit);
      logic [TIME_W-1:0] diff;
      diff = now - then;
      return (now >= then) && (TIME_W'(limit) < diff);
   endfunction

endpackage

@@ rtl/ltssa_cfg.sv @@
module ltssa_cfg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ltssa_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ltssa_pkg::IVL_W-1:0]         csr_data,
   output ltssa_pkg::cfg_type                  cfg
);
   import ltssa_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr;
   logic    ivl_ok;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;
   // intervals whose whole seconds exceed one month are refused
   assign ivl_ok    = csr_data < IVL_LIMIT;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (csr_index)
            CSR_START_THRESHOLD:  cfg_in.start_threshold = csr_data[LOAD_W-1:0];
            CSR_STOP_THRESHOLD:   cfg_in.stop_threshold  = csr_data[LOAD_W-1:0];
            CSR_START_HOLDOFF:    if (ivl_ok) cfg_in.start_holdoff_ns = csr_data;
            CSR_STOP_HOLDOFF:     if (ivl_ok) cfg_in.stop_holdoff_ns  = csr_data;
            CSR_QUIET_OVER_START: if (ivl_ok) cfg_in.quiet_after_over_start_ns = csr_data;
            CSR_QUIET_OVER_STOP:  if (ivl_ok) cfg_in.quiet_after_over_stop_ns  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_threshold           <= LOAD_W'(5);
         cfg_ff.stop_threshold            <= LOAD_W'(286);
         cfg_ff.start_holdoff_ns          <= IVL_W'(64'd70000000000);
         cfg_ff.stop_holdoff_ns           <= IVL_W'(64'd120000000000);
         cfg_ff.quiet_after_over_start_ns <= IVL_W'(64'd900000000000);
         cfg_ff.quiet_after_over_stop_ns  <= IVL_W'(64'd3600000000000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/ltssa_eval.sv @@
module ltssa_eval (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  ltssa_pkg::item_type     item,
   input  ltssa_pkg::cfg_type      cfg,
   output ltssa_pkg::result_type   result
);
   import ltssa_pkg::*;

   logic [TIME_W-1:0] last_start_ff, last_start_in;
   logic [TIME_W-1:0] last_stop_ff, last_stop_in;
   logic [TIME_W-1:0] last_over_start_ff, last_over_start_in;
   logic [TIME_W-1:0] last_over_stop_ff, last_over_stop_in;
   logic              start_gate;
   logic              stop_gate;

   // the three start tests and the stop test run side by side
   assign start_gate =
      elapsed_over(item.time_now, last_start_ff, cfg.start_holdoff_ns) &&
      elapsed_over(item.time_now, last_over_start_ff, cfg.quiet_after_over_start_ns) &&
      elapsed_over(item.time_now, last_over_stop_ff, cfg.quiet_after_over_stop_ns);
   assign stop_gate = elapsed_over(item.time_now, last_stop_ff, cfg.stop_holdoff_ns);

   always_comb begin
      result.status      = ST_OK;
      result.start_jobs  = '0;
      result.stop_jobs   = '0;
      last_start_in      = last_start_ff;
      last_stop_in       = last_stop_ff;
      last_over_start_in = last_over_start_ff;
      last_over_stop_in  = last_over_stop_ff;
      case (item.kind)
         KIND_START: begin
            if (!item.clock_ok) result.status = ST_CLOCK_FAIL;
            else                last_start_in = item.time_now;
         end
         KIND_STOP: begin
            if (!item.clock_ok) result.status = ST_CLOCK_FAIL;
            else                last_stop_in  = item.time_now;
         end
         KIND_POLL: begin
            if (!item.load_ok) begin
               result.status = ST_LOAD_FAIL;
            end else if (!item.clock_ok) begin
               result.status = ST_CLOCK_FAIL;
            end else begin
               if (item.load_sample < cfg.start_threshold) begin
                  if (start_gate)
                     result.start_jobs =
                        advise_count(cfg.start_threshold - item.load_sample);
               end else begin
                  last_over_start_in = item.time_now;
               end
               if (item.load_sample > cfg.stop_threshold) begin
                  if (stop_gate)
                     result.stop_jobs =
                        advise_count(item.load_sample - cfg.stop_threshold);
                  last_over_stop_in = item.time_now;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_start_ff      <= '0;
         last_stop_ff       <= '0;
         last_over_start_ff <= '0;
         last_over_stop_ff  <= '0;
      end else if (fire) begin
         last_start_ff      <= last_start_in;
         last_stop_ff       <= last_stop_in;
         last_over_start_ff <= last_over_start_in;
         last_over_stop_ff  <= last_over_stop_in;
      end
   end

endmodule

@@ rtl/load_threshold_start_stop_advisor.sv @@
// load threshold start/stop advisor
//
// req channel: one transfer per event (poll with load sample, start
// registered, stop registered); taken when req_valid is high and req_stall
// is low. rsp channel: exactly one result per event, in order, with status
// and the advised start and stop counts; taken when rsp_valid is high and
// rsp_stall is low. csr channel: register writes by index, always ready;
// write only while no event is in flight.
//
// an event waits in the input register while the timestamp subtracts and
// threshold compares run; its result is loaded into the output register
// once that register is empty or being drained, which raises rsp_valid.
// throughput: one event per cycle while the receiver does not stall, set
// by the single evaluation stage, which updates the stored timestamps in
// the same edge that loads the result so the next event sees them.
// a stalled receiver holds the result; the input register still takes one
// more event, then req_stall rises until the result is taken.
// reset empties both registers, loads the register defaults and clears
// the stored timestamps.
module load_threshold_start_stop_advisor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_kind,
   input  logic [ltssa_pkg::TIME_W-1:0]        req_time_now,
   input  logic [ltssa_pkg::LOAD_W-1:0]        req_load_sample,
   input  logic                                req_load_ok,
   input  logic                                req_clock_ok,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [ltssa_pkg::COUNT_W-1:0]       rsp_start_jobs,
   output logic [ltssa_pkg::COUNT_W-1:0]       rsp_stop_jobs,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ltssa_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ltssa_pkg::IVL_W-1:0]         csr_data
);
   import ltssa_pkg::*;

   cfg_type    cfg;
   result_type result;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff, s1_item_in;
   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   logic req_fire;
   logic advance;

   // item moves on when the output register is empty or being drained
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      s1_item_in.kind        = req_kind;
      s1_item_in.time_now    = req_time_now;
      s1_item_in.load_sample = req_load_sample;
      s1_item_in.load_ok     = req_load_ok;
      s1_item_in.clock_ok    = req_clock_ok;
      s1_valid_in  = req_fire || (s1_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
      rsp_in       = advance ? result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) s1_item_ff <= s1_item_in;
      rsp_ff <= rsp_in;
   end

   ltssa_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // state commits only when the item's result is loaded
   ltssa_eval u_eval (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (s1_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_start_jobs = rsp_ff.start_jobs;
   assign rsp_stop_jobs  = rsp_ff.stop_jobs;

   // a full input register behind a stalled result must hold off new transfers
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("input register overrun");

   // an item that leaves the input register always shows up as a result
   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("result lost after advance");

   // failed reads never advise anything
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_start_jobs == '0 && rsp_stop_jobs == '0))
      else $error("counts on failed status");

   // nothing is in flight right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !s1_valid_ff))
      else $error("pipeline not empty after reset");

endmodule

@@ sim/load_threshold_start_stop_advisor_tb.sv @@
module load_threshold_start_stop_advisor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ltssa_pkg::*;

   // kind code that the block leaves unused: it must answer ok with zero counts
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [63:0] NS_PER_SEC = 64'd1000000000;
   localparam logic [63:0] MONTH_SEC  = 64'd2592000;
   // largest interval still accepted, and the smallest one refused
   localparam logic [IVL_W-1:0] IVL_MONTH_MAX = IVL_W'(64'd2592000999999999);
   localparam logic [IVL_W-1:0] IVL_REFUSED   = IVL_W'(64'd2592001000000000);
   localparam logic [63:0] TIME_MAX = '1;
   localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

   // cycles with no transfer on any channel before the run is given up
   localparam int WATCHDOG_LIMIT = 4000;

   logic clock;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_kind = KIND_POLL;
   logic [TIME_W-1:0]      req_time_now = '0;
   logic [LOAD_W-1:0]      req_load_sample = '0;
   logic                   req_load_ok = 1'b0;
   logic                   req_clock_ok = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [1:0]             rsp_status;
   logic [COUNT_W-1:0]     rsp_start_jobs;
   logic [COUNT_W-1:0]     rsp_stop_jobs;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_START_THRESHOLD;
   logic [IVL_W-1:0]       csr_data = '0;

   load_threshold_start_stop_advisor dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_time_now    (req_time_now),
      .req_load_sample (req_load_sample),
      .req_load_ok     (req_load_ok),
      .req_clock_ok    (req_clock_ok),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_start_jobs  (rsp_start_jobs),
      .rsp_stop_jobs   (rsp_stop_jobs),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // advisor state as the testbench sees it
   // ---------------------------------------------------------------

   // register copies, loaded with the reset defaults
   logic [LOAD_W-1:0] thr_start     = 16'd5;
   logic [LOAD_W-1:0] thr_stop      = 16'd286;
   logic [IVL_W-1:0]  hold_start_ns = IVL_W'(64'd70000000000);
   logic [IVL_W-1:0]  hold_stop_ns  = IVL_W'(64'd120000000000);
   logic [IVL_W-1:0]  quiet_start_ns = IVL_W'(64'd900000000000);
   logic [IVL_W-1:0]  quiet_stop_ns  = IVL_W'(64'd3600000000000);

   // stored timestamps, cleared by reset
   logic [63:0] seen_start_ns = '0;
   logic [63:0] seen_stop_ns  = '0;
   logic [63:0] over_start_ns = '0;
   logic [63:0] over_stop_ns  = '0;

   // advice still owed by the block, oldest first
   result_type pending_advice[$];
   int mismatch_count = 0;

   // time base that the random events walk along
   logic [63:0] wall_ns = '0;
   int send_calm = 0;
   int idle_cycles = 0;

   // strict "more than limit has passed", a backward clock counts as no time at all
   function automatic logic held_past(input logic [63:0] now, input logic [63:0] then,
                                      input logic [IVL_W-1:0] limit);
      logic [63:0] gone;
      gone = (now >= then) ? now - then : 64'd0;
      return {{(64-IVL_W){1'b0}}, limit} < gone;
   endfunction

   // whole load units of the excess plus one, clipped to what the count port holds
   function automatic logic [COUNT_W-1:0] units_plus_one(input logic [LOAD_W-1:0] excess);
      logic [LOAD_W:0] c;
      c = {1'b0, excess >> LOAD_FRACTION_BITS} + 1'b1;
      return (c > (LOAD_W+1)'({COUNT_W{1'b1}})) ? {COUNT_W{1'b1}} : c[COUNT_W-1:0];
   endfunction

   // one event in, one piece of advice out; updates the stored timestamps
   function automatic result_type advise(input item_type ev);
      result_type r;
      r.status     = ST_OK;
      r.start_jobs = '0;
      r.stop_jobs  = '0;
      case (ev.kind)
         KIND_START, KIND_STOP: begin
            // load_ok plays no part in a registration
            if (!ev.clock_ok)
               r.status = ST_CLOCK_FAIL;
            else if (ev.kind == KIND_START)
               seen_start_ns = ev.time_now;
            else
               seen_stop_ns = ev.time_now;
         end
         KIND_POLL: begin
            // a failed load read wins over a failed clock read
            if (!ev.load_ok)
               r.status = ST_LOAD_FAIL;
            else if (!ev.clock_ok)
               r.status = ST_CLOCK_FAIL;
            else begin
               if (ev.load_sample < thr_start) begin
                  if (held_past(ev.time_now, seen_start_ns, hold_start_ns) &&
                      held_past(ev.time_now, over_start_ns, quiet_start_ns) &&
                      held_past(ev.time_now, over_stop_ns, quiet_stop_ns))
                     r.start_jobs = units_plus_one(thr_start - ev.load_sample);
               end else begin
                  over_start_ns = ev.time_now;
               end
               if (ev.load_sample > thr_stop) begin
                  if (held_past(ev.time_now, seen_stop_ns, hold_stop_ns))
                     r.stop_jobs = units_plus_one(ev.load_sample - thr_stop);
                  over_stop_ns = ev.time_now;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // mostly no gap, some short ones, a few long ones, and now and then a calm stretch
   function automatic int pick_gap(inout int calm);
      int unsigned r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 100);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // a load within three whole units of a threshold
   function automatic logic [LOAD_W-1:0] load_around(input logic [LOAD_W-1:0] thr);
      int v;
      v = int'(thr) + int'($urandom_range(0, 1536)) - 768;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[LOAD_W-1:0];
   endfunction

   // ---------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------

   // one event transfer; valid is left high so back-to-back events need no second write
   task automatic send_event(input logic [1:0] kind, input logic [63:0] t,
                             input logic [LOAD_W-1:0] load, input logic lok, input logic cok);
      item_type ev;
      int gap;
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      ev.kind        = kind;
      ev.time_now    = t;
      ev.load_sample = load;
      ev.load_ok     = lok;
      ev.clock_ok    = cok;
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_time_now    <= t;
      req_load_sample <= load;
      req_load_ok     <= lok;
      req_clock_ok    <= cok;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_advice.push_back(advise(ev));
   endtask

   // drop valid and let every owed result drain; the block holds nothing after that
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_advice.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // one register write; the testbench copy follows the same acceptance rules
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [IVL_W-1:0] data);
      logic month_ok;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      // intervals whose whole seconds go past one month are refused
      month_ok = ({{(64-IVL_W){1'b0}}, data} / NS_PER_SEC) <= MONTH_SEC;
      case (idx)
         CSR_START_THRESHOLD:  thr_start = data[LOAD_W-1:0];
         CSR_STOP_THRESHOLD:   thr_stop  = data[LOAD_W-1:0];
         CSR_START_HOLDOFF:    if (month_ok) hold_start_ns  = data;
         CSR_STOP_HOLDOFF:     if (month_ok) hold_stop_ns   = data;
         CSR_QUIET_OVER_START: if (month_ok) quiet_start_ns = data;
         CSR_QUIET_OVER_STOP:  if (month_ok) quiet_stop_ns  = data;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_all(input logic [LOAD_W-1:0] s_thr, input logic [LOAD_W-1:0] p_thr,
                          input logic [IVL_W-1:0] h_start, input logic [IVL_W-1:0] h_stop,
                          input logic [IVL_W-1:0] q_start, input logic [IVL_W-1:0] q_stop);
      wait_idle();
      // junk above the low 16 bits of a threshold write must be dropped
      write_reg(CSR_START_THRESHOLD, {$urandom, 4'h0, s_thr});
      write_reg(CSR_STOP_THRESHOLD,  {$urandom, 4'h0, p_thr});
      write_reg(CSR_START_HOLDOFF,    h_start);
      write_reg(CSR_STOP_HOLDOFF,     h_stop);
      write_reg(CSR_QUIET_OVER_START, q_start);
      write_reg(CSR_QUIET_OVER_STOP,  q_stop);
   endtask

   // random walk of events: mostly polls, some registrations, a few failures and
   // unused kinds; time mostly moves forward and sometimes steps back
   task automatic random_events(input int n, input int unsigned step);
      int unsigned r;
      logic [1:0] kind;
      logic [LOAD_W-1:0] load;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 5)
            wall_ns = wall_ns - 64'($urandom_range(0, 2 * step));
         else
            wall_ns = wall_ns + 64'($urandom_range(0, step));
         r = $urandom_range(0, 99);
         if (r < 70)      kind = KIND_POLL;
         else if (r < 84) kind = KIND_START;
         else if (r < 98) kind = KIND_STOP;
         else             kind = KIND_UNUSED;
         r = $urandom_range(0, 9);
         if (r < 4)      load = load_around(thr_start);
         else if (r < 8) load = load_around(thr_stop);
         else            load = LOAD_W'($urandom);
         send_event(kind, wall_ns, load, $urandom_range(0, 19) != 0,
                    $urandom_range(0, 19) != 0);
      end
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // reset defaults: strict boundaries, failures, backward time, time extremes
   task automatic test_reset_defaults();
      logic [63:0] t1;
      t1 = 64'd4000000000000;
      send_event(KIND_POLL, 64'd0, 16'd0, 1'b1, 1'b1);          // nothing has elapsed yet
      send_event(KIND_POLL, t1, 16'd0, 1'b1, 1'b1);             // all quiet times passed
      send_event(KIND_POLL, t1 + 1, LOAD_MAX, 1'b1, 1'b1);      // largest stop advice
      send_event(KIND_POLL, t1 + 2, 16'd0, 1'b1, 1'b1);         // held by the quiet time
      send_event(KIND_START, t1 + 3, 16'd0, 1'b1, 1'b1);
      send_event(KIND_STOP, t1 + 3, LOAD_MAX, 1'b1, 1'b1);
      send_event(KIND_START, 64'd0, 16'd0, 1'b1, 1'b0);         // clock fail keeps stored time
      send_event(KIND_STOP, TIME_MAX, 16'd0, 1'b0, 1'b0);       // load_ok ignored here
      send_event(KIND_POLL, TIME_MAX, 16'd0, 1'b0, 1'b0);       // load fail reported first
      send_event(KIND_POLL, TIME_MAX, 16'd0, 1'b1, 1'b0);
      send_event(KIND_UNUSED, TIME_MAX, LOAD_MAX, 1'b1, 1'b1);
      send_event(KIND_POLL, 64'd1, 16'h0200, 1'b1, 1'b1);       // time ran backward
      send_event(KIND_POLL, TIME_MAX, 16'd0, 1'b1, 1'b1);
      send_event(KIND_POLL, t1 + 10, 16'd5, 1'b1, 1'b1);        // load equal to start level
      send_event(KIND_POLL, t1 + 11, 16'd286, 1'b1, 1'b1);      // load equal to stop level
      // stop holdoff exactly used up, then one past it
      send_event(KIND_POLL, t1 + 3 + 64'd120000000000, 16'd287, 1'b1, 1'b1);
      send_event(KIND_POLL, t1 + 4 + 64'd120000000000, 16'd287, 1'b1, 1'b1);
   endtask

   // threshold and interval extremes, refused interval writes, largest counts
   task automatic test_register_extremes();
      logic [63:0] t2;
      t2 = 64'h0000_1000_0000_0000;
      wait_idle();
      write_reg(CSR_START_THRESHOLD, 52'hA_BCDE_F012_FFFF);
      write_reg(CSR_STOP_THRESHOLD,  52'hF_FFFF_FFFF_0000);
      write_reg(CSR_START_HOLDOFF,    52'd100);
      write_reg(CSR_STOP_HOLDOFF,     IVL_MONTH_MAX);
      write_reg(CSR_STOP_HOLDOFF,     52'hF_FFFF_FFFF_FFFF);     // refused
      write_reg(CSR_QUIET_OVER_START, 52'd0);
      write_reg(CSR_QUIET_OVER_STOP,  52'd0);
      write_reg(CSR_QUIET_OVER_START, IVL_REFUSED);              // refused
      write_reg(CSR_QUIET_OVER_STOP,  IVL_REFUSED);              // refused
      send_event(KIND_START, t2, 16'd0, 1'b0, 1'b1);
      send_event(KIND_POLL, t2 + 100, 16'd0, 1'b1, 1'b1);       // holdoff exactly used up
      send_event(KIND_POLL, t2 + 101, 16'd0, 1'b1, 1'b1);       // largest start advice
      send_event(KIND_POLL, t2 + 102, LOAD_MAX, 1'b1, 1'b1);    // month-long stop holdoff
      wait_idle();
      write_reg(CSR_STOP_HOLDOFF, 52'd0);
      send_event(KIND_POLL, t2 + 103, LOAD_MAX, 1'b1, 1'b1);    // largest stop advice
      send_event(KIND_POLL, t2 + 103, 16'hFFFE, 1'b1, 1'b1);    // zero quiet, zero elapsed
      send_event(KIND_POLL, t2 + 104, 16'hFFFE, 1'b1, 1'b1);    // start and stop together
   endtask

   // moderate levels, short intervals against a slow walking clock
   task automatic test_random_moderate();
      set_all(16'h0300, 16'h0500, 52'd300, 52'd400, 52'd150, 52'd250);
      wall_ns = {4'h1, 28'($urandom), $urandom};
      random_events(450, 200);
   endtask

   // nearly every load is below the start level and above the stop level, no waiting
   task automatic test_random_wide_open();
      set_all(LOAD_MAX, 16'd0, 52'd0, 52'd0, 52'd0, 52'd0);
      wall_ns = {4'h4, 28'($urandom), $urandom};
      random_events(350, 3);
   endtask

   // no load can ever trigger advice, intervals at the one-month ceiling
   task automatic test_random_closed();
      set_all(16'd0, LOAD_MAX, IVL_MONTH_MAX, IVL_MONTH_MAX, IVL_MONTH_MAX, IVL_MONTH_MAX);
      wall_ns = {4'h8, 28'($urandom), $urandom};
      random_events(200, 200);
   endtask

   // a few random settings, each preceded by refused interval writes
   task automatic test_random_shuffled();
      int unsigned step;
      logic [LOAD_W-1:0] s_thr;
      wall_ns = {4'hC, 28'($urandom), $urandom};
      for (int round = 0; round < 4; round++) begin
         step  = $urandom_range(50, 400);
         s_thr = LOAD_W'($urandom_range(0, 16'h0800));
         wait_idle();
         write_reg(CSR_START_HOLDOFF,    IVL_REFUSED + IVL_W'($urandom));
         write_reg(CSR_STOP_HOLDOFF,     IVL_REFUSED + IVL_W'($urandom));
         write_reg(CSR_QUIET_OVER_START, IVL_REFUSED + IVL_W'($urandom));
         write_reg(CSR_QUIET_OVER_STOP,  IVL_REFUSED + IVL_W'($urandom));
         set_all(s_thr, s_thr + LOAD_W'($urandom_range(0, 16'h0800)),
                 IVL_W'($urandom_range(0, 2 * step)), IVL_W'($urandom_range(0, 2 * step)),
                 IVL_W'($urandom_range(0, 2 * step)), IVL_W'($urandom_range(0, 2 * step)));
         random_events(175, step);
      end
   endtask

   // ---------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------

   // receiver back-pressure, same gap profile as the sender
   initial begin
      int calm;
      int n;
      calm = 0;
      forever begin
         n = pick_gap(calm);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   end

   // every result transfer against the oldest owed advice
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_advice.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("result with none owed: status %0d starts %0d stops %0d",
                        rsp_status, rsp_start_jobs, rsp_stop_jobs);
         end else begin
            want = pending_advice.pop_front();
            if (rsp_status !== want.status || rsp_start_jobs !== want.start_jobs ||
                rsp_stop_jobs !== want.stop_jobs) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("advice differs: status %0d/%0d starts %0d/%0d stops %0d/%0d",
                           want.status, rsp_status, want.start_jobs, rsp_start_jobs,
                           want.stop_jobs, rsp_stop_jobs);
            end
         end
      end
   end

   // give up when no channel has moved for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // ---------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_register_extremes();
      test_random_moderate();
      test_random_wide_open();
      test_random_closed();
      test_random_shuffled();
      // drain, then a few more cycles for anything stray
      wait_idle();
      repeat (8) @(posedge clock);
      mismatch_count += pending_advice.size();
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
